// ===== hdl/kf2d_pkg.sv =====
// ----------------------------------------------------------------------------
// kf2d_pkg: shared definitions for the 2-D identity-model Kalman filter
// Field widths, item kinds, register indexes and the 32-bit saturation helper
// used by the filter datapath and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package kf2d_pkg;

	// Default number of fraction bits of the signed fixed-point values.
	localparam int FRAC_BITS_DEF = 16;

	// Widths of the stored values and of the streaming fields.
	localparam int DATA_W  = 32;
	localparam int NOISE_W = 24;
	localparam int KIND_W  = 2;
	localparam int CFG_IDX_W = 8;

	// Item kinds carried on the input tuser.
	localparam logic [KIND_W-1:0] KIND_INIT    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PREDICT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UPDATE  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 8'd1;

	// Limits of a signed 32-bit value.
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	// Clamp a wide signed value into the signed 32-bit range.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic fits;
		fits = (v[63:DATA_W-1] == {(64-DATA_W+1){v[63]}});
		if (fits) begin
			return v[DATA_W-1:0];
		end else if (v[63]) begin
			return S32_MIN;
		end else begin
			return S32_MAX;
		end
	endfunction

endpackage

`default_nettype wire

// ===== hdl/kalman_filter_2d_identity.sv =====
// ----------------------------------------------------------------------------
// kalman_filter_2d_identity: 2-D Kalman filter with identity models
// Init, predict and update on a two-component signed fixed-point state with
// a 2x2 covariance, using one shared multiplier and one iterative divider.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns one result for each item.
// Init and predict results, and items of the unused kind, pass from idle
// to the done state and then to the output register. An update runs 22
// products through the shared 32x32 multiplier and four gain divisions
// through the bit-serial divider, most of it the four 32-step quotient
// sequences; an update with a singular P + R stops at det(S). The input
// is ready again once the result has moved into the output register, so a
// new item is taken while a finished result still waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_filter_2d_identity
	import kf2d_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// Input items.
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire  [2*DATA_W-1:0]   s_axis_tdata,   // in_x [31:0], in_y [63:32]
	input  wire  [KIND_W-1:0]     s_axis_tuser,   // kind [1:0]
	// Result items.
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	output logic [2*DATA_W-1:0]   m_axis_tdata,   // est_x [31:0], est_y [63:32]
	output logic [0:0]            m_axis_tuser,   // singular [0]
	// Register writes.
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [NOISE_W-1:0]    cfg_data
);

	// Widths of a shifted product and of a difference of two of them.
	localparam int AW = 2 * DATA_W - FRAC_BITS;
	localparam int PW = AW + 1;

	localparam logic [NOISE_W-1:0] NOISE_RESET =
		NOISE_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(64'd1 << FRAC_BITS);

	// Multiply program: steps 0..9 form det(S) and P * adj(S), steps 10..21
	// the estimate correction and the new covariance. Products go in pairs.
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_A_LAST = 5'd9;
	localparam logic [STEP_W-1:0] STEP_B_LAST = 5'd21;

	localparam logic [3:0] PAIR_DET = 4'd0;
	localparam logic [3:0] PAIR_M0  = 4'd1;
	localparam logic [3:0] PAIR_M1  = 4'd2;
	localparam logic [3:0] PAIR_M2  = 4'd3;
	localparam logic [3:0] PAIR_M3  = 4'd4;
	localparam logic [3:0] PAIR_E0  = 4'd5;
	localparam logic [3:0] PAIR_E1  = 4'd6;
	localparam logic [3:0] PAIR_C00 = 4'd7;
	localparam logic [3:0] PAIR_C01 = 4'd8;
	localparam logic [3:0] PAIR_C10 = 4'd9;
	localparam logic [3:0] PAIR_C11 = 4'd10;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL_A = 5'b00010,
		ST_DIV   = 5'b00100,
		ST_MUL_B = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t                    state_q;
	logic [STEP_W-1:0]         step_q;
	logic [1:0]                div_idx_q;
	logic                      div_run_q;
	logic                      sing_q;
	logic                      out_valid_q;
	logic [NOISE_W-1:0]        q_noise_q;
	logic [NOISE_W-1:0]        r_noise_q;
	logic signed [DATA_W-1:0]  est_q [2];
	logic signed [DATA_W-1:0]  p_q [4];

	logic signed [DATA_W-1:0]  pn_q [3];
	logic signed [DATA_W-1:0]  k_q [4];
	logic signed [DATA_W-1:0]  vx_q;
	logic signed [DATA_W-1:0]  vy_q;
	logic signed [DATA_W-1:0]  s00_q;
	logic signed [DATA_W-1:0]  s11_q;
	logic signed [PW-1:0]      det_q;
	logic signed [PW-1:0]      m_q [4];
	logic signed [AW-1:0]      acc_q;
	logic [2*DATA_W-1:0]       out_data_q;
	logic                      out_sing_q;

	logic                      valid_s1;
	logic [STEP_W-1:0]         step_s1;
	logic signed [2*DATA_W-1:0] prod_s1;

	logic                      in_xfer;
	logic                      out_free;
	logic                      out_load;
	logic                      issue;
	logic signed [DATA_W-1:0]  in_x;
	logic signed [DATA_W-1:0]  in_y;
	logic signed [DATA_W-1:0]  op_a;
	logic signed [DATA_W-1:0]  op_b;
	logic signed [AW-1:0]      prod_sh;
	logic signed [PW-1:0]      pair_res;
	logic [3:0]                pair_s1;
	logic                      pair_done;
	logic                      div_start;
	logic                      div_done;
	logic signed [DATA_W-1:0]  div_quo;

	assign in_x     = s_axis_tdata[DATA_W-1:0];
	assign in_y     = s_axis_tdata[2*DATA_W-1:DATA_W];
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_DONE) && out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sing_q;

	// Issue one product per cycle while a multiply phase runs.
	assign issue = ((state_q == ST_MUL_A) && (step_q <= STEP_A_LAST)) ||
		((state_q == ST_MUL_B) && (step_q <= STEP_B_LAST));

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (step_q)
			5'd0:  begin op_a = s00_q;  op_b = s11_q;  end
			5'd1:  begin op_a = p_q[1]; op_b = p_q[2]; end
			5'd2:  begin op_a = p_q[0]; op_b = s11_q;  end
			5'd3:  begin op_a = p_q[1]; op_b = p_q[2]; end
			5'd4:  begin op_a = p_q[1]; op_b = s00_q;  end
			5'd5:  begin op_a = p_q[0]; op_b = p_q[1]; end
			5'd6:  begin op_a = p_q[2]; op_b = s11_q;  end
			5'd7:  begin op_a = p_q[3]; op_b = p_q[2]; end
			5'd8:  begin op_a = p_q[3]; op_b = s00_q;  end
			5'd9:  begin op_a = p_q[2]; op_b = p_q[1]; end
			5'd10: begin op_a = k_q[0]; op_b = vx_q;   end
			5'd11: begin op_a = k_q[1]; op_b = vy_q;   end
			5'd12: begin op_a = k_q[2]; op_b = vx_q;   end
			5'd13: begin op_a = k_q[3]; op_b = vy_q;   end
			5'd14: begin op_a = k_q[0]; op_b = p_q[0]; end
			5'd15: begin op_a = k_q[1]; op_b = p_q[2]; end
			5'd16: begin op_a = k_q[0]; op_b = p_q[1]; end
			5'd17: begin op_a = k_q[1]; op_b = p_q[3]; end
			5'd18: begin op_a = k_q[2]; op_b = p_q[0]; end
			5'd19: begin op_a = k_q[3]; op_b = p_q[2]; end
			5'd20: begin op_a = k_q[2]; op_b = p_q[1]; end
			5'd21: begin op_a = k_q[3]; op_b = p_q[3]; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	// Shifted product (floor), and the pair result: the first phase subtracts
	// the second product of a pair, the second phase adds it.
	assign prod_sh   = prod_s1[2*DATA_W-1:FRAC_BITS];
	assign pair_s1   = step_s1[STEP_W-1:1];
	assign pair_done = valid_s1 && step_s1[0];
	assign pair_res  = (step_s1 <= STEP_A_LAST) ? (PW'(acc_q) - PW'(prod_sh)) :
		(PW'(acc_q) + PW'(prod_sh));

	// Gain divider, started once for each gain entry.
	assign div_start = (state_q == ST_DIV) && !div_run_q;

	kf2d_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (m_q[div_idx_q]),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Sequencer, filter state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			div_idx_q   <= '0;
			div_run_q   <= 1'b0;
			sing_q      <= 1'b0;
			out_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			q_noise_q   <= NOISE_RESET;
			r_noise_q   <= NOISE_RESET;
			est_q[0]    <= '0;
			est_q[1]    <= '0;
			p_q[0]      <= ONE_FX;
			p_q[1]      <= '0;
			p_q[2]      <= '0;
			p_q[3]      <= ONE_FX;
		end else begin
			// Register writes; unknown indexes are dropped.
			if (cfg_valid) begin
				case (cfg_index)
					CFG_PROCESS_NOISE:     q_noise_q <= cfg_data;
					CFG_MEASUREMENT_NOISE: r_noise_q <= cfg_data;
					default: ;
				endcase
			end

			// Output register: filled by a finished item, emptied by a result transfer.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			valid_s1 <= issue;
			if (issue) begin
				step_q <= step_q + 1'b1;
			end

			if (div_start) begin
				div_run_q <= 1'b1;
			end else if (div_done) begin
				div_run_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						sing_q <= 1'b0;
						case (s_axis_tuser)
							KIND_INIT: begin
								est_q[0] <= in_x;
								est_q[1] <= in_y;
								state_q  <= ST_DONE;
							end
							KIND_PREDICT: begin
								p_q[0] <= sat32(64'(p_q[0]) + signed'(64'(q_noise_q)));
								p_q[3] <= sat32(64'(p_q[3]) + signed'(64'(q_noise_q)));
								state_q <= ST_DONE;
							end
							KIND_UPDATE: begin
								step_q  <= '0;
								state_q <= ST_MUL_A;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_MUL_A: begin
					if (valid_s1 && (step_s1 == STEP_A_LAST)) begin
						if (det_q == '0) begin
							sing_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							div_idx_q <= '0;
							state_q   <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (div_idx_q == 2'd3) begin
							state_q <= ST_MUL_B;
						end else begin
							div_idx_q <= div_idx_q + 1'b1;
						end
					end
				end
				ST_MUL_B: begin
					if (valid_s1 && (step_s1 == STEP_B_LAST)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Estimate and covariance writes from the second phase. The new
			// covariance is committed whole when its last entry is ready.
			if (pair_done) begin
				case (pair_s1)
					PAIR_E0: est_q[0] <= sat32(64'(est_q[0]) + 64'(pair_res));
					PAIR_E1: est_q[1] <= sat32(64'(est_q[1]) + 64'(pair_res));
					PAIR_C11: begin
						p_q[0] <= pn_q[0];
						p_q[1] <= pn_q[1];
						p_q[2] <= pn_q[2];
						p_q[3] <= sat32(64'(p_q[3]) - 64'(pair_res));
					end
					default: ;
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		// Innovation and S diagonal, fixed for the whole update.
		if (in_xfer) begin
			vx_q  <= sat32(64'(in_x) - 64'(est_q[0]));
			vy_q  <= sat32(64'(in_y) - 64'(est_q[1]));
			s00_q <= sat32(64'(p_q[0]) + signed'(64'(r_noise_q)));
			s11_q <= sat32(64'(p_q[3]) + signed'(64'(r_noise_q)));
		end

		// Multiplier stage.
		prod_s1 <= op_a * op_b;
		step_s1 <= step_q;

		// Accumulate stage: hold the first product of a pair, store the result.
		if (valid_s1 && !step_s1[0]) begin
			acc_q <= prod_sh;
		end
		if (pair_done) begin
			case (pair_s1)
				PAIR_DET: det_q   <= pair_res;
				PAIR_M0:  m_q[0]  <= pair_res;
				PAIR_M1:  m_q[1]  <= pair_res;
				PAIR_M2:  m_q[2]  <= pair_res;
				PAIR_M3:  m_q[3]  <= pair_res;
				PAIR_C00: pn_q[0] <= sat32(64'(p_q[0]) - 64'(pair_res));
				PAIR_C01: pn_q[1] <= sat32(64'(p_q[1]) - 64'(pair_res));
				PAIR_C10: pn_q[2] <= sat32(64'(p_q[2]) - 64'(pair_res));
				default: ;
			endcase
		end

		// Gain entries from the divider.
		if ((state_q == ST_DIV) && div_done) begin
			k_q[div_idx_q] <= div_quo;
		end

		// Output register load.
		if (out_load) begin
			out_data_q <= {est_q[1], est_q[0]};
			out_sing_q <= sing_q;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/kf2d_div.sv =====
// ----------------------------------------------------------------------------
// kf2d_div: iterative fixed-point divider for the Kalman gain
// Computes (num << FRAC_BITS) / den, truncated toward zero and saturated to
// the signed 32-bit range, one quotient bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module kf2d_div
	import kf2d_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	input  wire  signed [2*DATA_W-FRAC_BITS:0]  num,
	input  wire  signed [2*DATA_W-FRAC_BITS:0]  den,
	output logic                                done,
	output logic signed [DATA_W-1:0]            quo
);

	// Operand width and the width of the scaled dividend.
	localparam int PW    = 2 * DATA_W + 1 - FRAC_BITS;
	localparam int NW    = PW + FRAC_BITS;
	localparam int HI_W  = NW - DATA_W;
	localparam int CNT_W = $clog2(DATA_W + 2);
	localparam logic [CNT_W-1:0] CNT_CHECK = '0;
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DATA_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PW-1:0]        rem_q;
	logic [PW-1:0]        d_q;
	logic [DATA_W-1:0]    lo_q;
	logic [DATA_W-1:0]    q_q;
	logic                 sat_q;
	logic                 neg_q;
	logic signed [DATA_W-1:0] quo_q;

	logic [PW-1:0]        num_abs;
	logic [PW-1:0]        den_abs;
	logic [NW-1:0]        num_scaled;
	logic [PW:0]          trial;
	logic [PW:0]          trial_diff;
	logic                 trial_ge;
	logic [DATA_W-1:0]    limit;
	logic [DATA_W-1:0]    mag;

	// Magnitudes of the operands and the dividend shifted up by the fraction bits.
	assign num_abs    = num[PW-1] ? PW'(-num) : PW'(num);
	assign den_abs    = den[PW-1] ? PW'(-den) : PW'(den);
	assign num_scaled = {num_abs, {FRAC_BITS{1'b0}}};

	// One restoring step: bring down the next dividend bit and try to subtract.
	assign trial      = {rem_q, lo_q[DATA_W-1]};
	assign trial_diff = trial - {1'b0, d_q};
	assign trial_ge   = (trial >= {1'b0, d_q});

	// Saturation to the largest magnitude of the result's sign.
	assign limit = neg_q ? DATA_W'(S32_MIN) : DATA_W'(S32_MAX);
	assign mag   = (sat_q || (q_q > limit)) ? limit : q_q;

	// Sequence control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_CHECK;
			end else if (busy_q) begin
				if (cnt_q > CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Remainder, quotient and result registers.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[PW-1] ^ den[PW-1];
			d_q   <= den_abs;
			rem_q <= PW'(num_scaled[NW-1:DATA_W]);
			lo_q  <= num_scaled[DATA_W-1:0];
			q_q   <= '0;
		end else if (busy_q) begin
			if (cnt_q == CNT_CHECK) begin
				// A quotient of 2^32 or more saturates whatever the low bits are.
				sat_q <= (rem_q >= d_q);
			end else if (cnt_q <= CNT_LAST) begin
				rem_q <= trial_ge ? trial_diff[PW-1:0] : trial[PW-1:0];
				q_q   <= {q_q[DATA_W-2:0], trial_ge};
				lo_q  <= {lo_q[DATA_W-2:0], 1'b0};
			end else begin
				quo_q <= neg_q ? signed'(-mag) : signed'(mag);
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	// The high part of the scaled dividend is narrower than the remainder.
	if (HI_W > PW) begin : g_width_check
		$error("kf2d_div: FRAC_BITS out of range");
	end

endmodule

`default_nettype wire
